// ----- design/rrf_pkg.sv -----
// ----------------------------------------------------------------------------
// rrf_pkg
// Shared constants, payload types and operation codes of the rotating
// register file.
// ----------------------------------------------------------------------------
package rrf_pkg;

   // store geometry
   localparam int TOTAL_REGS = 128;
   localparam int DATA_W     = 64;
   localparam int ADDR_W     = $clog2(TOTAL_REGS);

   // field widths
   localparam int OP_W    = 3;
   localparam int IDX_W   = 8;
   localparam int BASE_W  = 7;
   localparam int SC_W    = 7;

   // width of the ring offset sum and of the ring size (up to 255 + 127)
   localparam int SUM_W   = 9;
   localparam int CNT_W   = $clog2(SUM_W + 1);

   localparam logic [SC_W-1:0] STATIC_COUNT_RESET = 7'd32;

   typedef enum logic [OP_W-1:0] {
      OP_READ_LOG  = 3'd0,
      OP_WRITE_LOG = 3'd1,
      OP_READ_PHY  = 3'd2,
      OP_WRITE_PHY = 3'd3,
      OP_CLEAR     = 3'd4
   } op_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [IDX_W-1:0]  reg_index;
      logic [BASE_W-1:0] rot_base;
      logic [DATA_W-1:0] write_data;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              error;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic step;
      logic go;
      logic rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_done;
      logic rsp_free;
   } status_type;

endpackage

// ----- design/rotating_register_file_unit.sv -----
// ----------------------------------------------------------------------------
// rotating_register_file_unit
// A request beat is captured; a logical access to a rotating register then
// runs a bit-serial ring remainder before the store access. The unit takes
// one request at a time: a new one is accepted only after the last result
// has been loaded into the response register.
// Reset clears the store at once through per-entry valid bits, and the
// static count returns to 32. Clear-all drops every valid bit at once.
// ----------------------------------------------------------------------------
module rotating_register_file_unit
   import rrf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_type         req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_type         rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [SC_W-1:0] csr_data
);

   cmd_type    cmd;
   status_type status;

   rrf_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   rrf_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_valid (csr_valid),
      .csr_data  (csr_data)
   );

   // accept a configuration beat in any cycle
   assign csr_ready = 1'b1;

endmodule

// ----- design/rrf_ram.sv -----
// ----------------------------------------------------------------------------
// rrf_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module rrf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write or read one word
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/rrf_datapath.sv -----
// ----------------------------------------------------------------------------
// rrf_datapath
// Request capture, index mapping with a bit-serial ring remainder, the
// register store with per-entry valid bits, and the response register.
// ----------------------------------------------------------------------------
module rrf_datapath
   import rrf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cmd_type         cmd,
   output status_type      status,
   input  req_type         req_data,
   output rsp_type         rsp_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  logic            csr_valid,
   input  logic [SC_W-1:0] csr_data
);

   logic [SC_W-1:0]       sc_ff, sc_in;
   req_type               req_ff, req_in;
   logic                  err_ff, err_in;
   logic                  need_div_ff, need_div_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [SUM_W-1:0]      rem_ff, rem_in;
   logic [SUM_W-1:0]      ring_ff, ring_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [TOTAL_REGS-1:0] valid_ff, valid_in;
   logic                  rd_use_ff, rd_use_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  in_range;
   logic                  is_logical;
   logic                  is_access;
   logic                  rotating;
   logic [SUM_W-1:0]      trial;
   logic [SUM_W:0]        shifted;
   logic [ADDR_W-1:0]     map_addr;
   logic                  do_read;
   logic                  do_write;
   logic                  do_clear;
   logic [DATA_W-1:0]     ram_rdata;

   // classify the incoming request
   always_comb begin
      in_range   = {1'b0, req_data.reg_index} < SUM_W'(TOTAL_REGS);
      is_logical = (req_data.op == OP_READ_LOG) || (req_data.op == OP_WRITE_LOG);
      is_access  = req_data.op <= OP_W'(OP_WRITE_PHY);
      rotating   = is_logical && in_range
                   && (req_data.reg_index >= IDX_W'(sc_ff))
                   && (SUM_W'(sc_ff) < SUM_W'(TOTAL_REGS));
   end

   // one restoring remainder step
   always_comb begin
      shifted = {rem_ff, sum_ff[SUM_W-1]};
      if (shifted >= {1'b0, ring_ff}) begin
         trial = SUM_W'(shifted - {1'b0, ring_ff});
      end else begin
         trial = shifted[SUM_W-1:0];
      end
   end

   // final physical address and store operation
   always_comb begin
      if (need_div_ff) begin
         map_addr = ADDR_W'(SUM_W'(sc_ff) + rem_ff);
      end else begin
         map_addr = addr_ff;
      end
      do_read  = !err_ff && ((req_ff.op == OP_READ_LOG) || (req_ff.op == OP_READ_PHY));
      do_write = !err_ff && ((req_ff.op == OP_WRITE_LOG) || (req_ff.op == OP_WRITE_PHY));
      do_clear = req_ff.op == OP_CLEAR;
   end

   // next-state logic
   always_comb begin
      sc_in        = sc_ff;
      req_in       = req_ff;
      err_in       = err_ff;
      need_div_in  = need_div_ff;
      addr_in      = addr_ff;
      sum_in       = sum_ff;
      rem_in       = rem_ff;
      ring_in      = ring_ff;
      count_in     = count_ff;
      valid_in     = valid_ff;
      rd_use_in    = rd_use_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      // take a configuration beat
      if (csr_valid) begin
         sc_in = csr_data;
      end

      // capture a request beat and set up the remainder
      if (cmd.load) begin
         req_in      = req_data;
         err_in      = is_access && !in_range;
         need_div_in = rotating;
         addr_in     = req_data.reg_index[ADDR_W-1:0];
         sum_in      = SUM_W'({1'b0, req_data.reg_index} - SUM_W'(sc_ff)
                              + SUM_W'(req_data.rot_base));
         ring_in     = SUM_W'(TOTAL_REGS) - SUM_W'(sc_ff);
         rem_in      = '0;
         count_in    = rotating ? CNT_W'(SUM_W) : '0;
      end

      // advance the remainder one bit
      if (cmd.step) begin
         rem_in   = trial;
         sum_in   = {sum_ff[SUM_W-2:0], 1'b0};
         count_in = count_ff - 1'b1;
      end

      // apply the store operation
      if (cmd.go) begin
         rd_use_in = do_read && valid_ff[map_addr];
         if (do_clear) begin
            valid_in = '0;
         end else if (do_write) begin
            valid_in[map_addr] = 1'b1;
         end
      end

      // drop a delivered beat, then load a new one
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_in.read_data = rd_use_ff ? ram_rdata : '0;
         rsp_in.error     = err_ff;
         rsp_valid_in     = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sc_ff        <= STATIC_COUNT_RESET;
         count_ff     <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sc_ff        <= sc_in;
         count_ff     <= count_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      err_ff      <= err_in;
      need_div_ff <= need_div_in;
      addr_ff     <= addr_in;
      sum_ff      <= sum_in;
      rem_ff      <= rem_in;
      ring_ff     <= ring_in;
      rd_use_ff   <= rd_use_in;
      rsp_ff      <= rsp_in;
   end

   rrf_ram #(
      .WIDTH (DATA_W),
      .DEPTH (TOTAL_REGS)
   ) u_store (
      .clock (clock),
      .en    (cmd.go && (do_read || do_write)),
      .we    (do_write),
      .addr  (map_addr),
      .wdata (req_ff.write_data),
      .rdata (ram_rdata)
   );

   assign status.div_done = count_ff == '0;
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;
   assign rsp_data        = rsp_ff;
   assign rsp_valid       = rsp_valid_ff;

endmodule

// ----- design/rrf_controller.sv -----
// ----------------------------------------------------------------------------
// rrf_controller
// Sequencer for one access: capture, remainder steps, store access and
// hand-off to the response register.
// ----------------------------------------------------------------------------
module rrf_controller
   import rrf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output cmd_type    cmd,
   input  status_type status
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   // decode commands and next state
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (status.div_done) begin
               cmd.go   = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         S_DONE: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/rrf_checker.sv -----
// ----------------------------------------------------------------------------
// rrf_port_checker
// Port-level checks of the rotating register file, bound to the top level.
// ----------------------------------------------------------------------------
module rrf_port_checker
   import rrf_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_type         rsp_data
);

   logic [1:0] pend_ff, pend_in;
   logic       in_beat;
   logic       out_beat;

   assign in_beat  = req_valid && req_ready;
   assign out_beat = rsp_valid && rsp_ready;

   // track beats in flight
   always_comb begin
      pend_in = pend_ff;
      if (in_beat && !out_beat) begin
         pend_in = pend_ff + 1'b1;
      end else if (out_beat && !in_beat) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // an error response carries zero data
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error |-> rsp_data.read_data == '0)
      else $error("error response with nonzero data");

   // no response without a request in flight
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("response without request");

   // at most one request at work and one waiting response
   a_depth: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= 2'd2)
      else $error("too many requests in flight");

   // the unit works on one request at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      in_beat |=> !req_ready)
      else $error("request taken while busy");

endmodule

bind rotating_register_file_unit rrf_port_checker u_rrf_checker (.*);
